// ===== rtl/core/ikf_pkg.sv =====
`default_nettype none

package ikf_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    localparam logic [2:0] MODE_SOBEL   = 3'd0;
    localparam logic [2:0] MODE_MEDIAN  = 3'd1;
    localparam logic [2:0] MODE_GAUSS   = 3'd2;
    localparam logic [2:0] MODE_EMBOSS  = 3'd3;
    localparam logic [2:0] MODE_SHARPEN = 3'd4;
    localparam logic [2:0] MODE_BLUR    = 3'd5;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [11:0] WIDTH_MIN   = 12'd3;
    localparam logic [11:0] WIDTH_MAX   = 12'(MAX_WIDTH);
    localparam logic [12:0] HEIGHT_MIN  = 13'd3;
    localparam logic [12:0] HEIGHT_MAX  = 13'd4096;
    localparam logic [11:0] WIDTH_RST   = 12'd640;
    localparam logic [12:0] HEIGHT_RST  = 13'd480;

    // reciprocal of 5 in 2^-18 units, exact for 14-bit dividends
    localparam logic [15:0] RECIP5 = 16'd52429;

    typedef logic [31:0] pixel_t;

    typedef struct packed {
        logic              emit;
        logic              border;
        logic              last;
        logic [ADDR_W-1:0] addr;
        pixel_t            px;
    } item_t;

    typedef struct packed {
        logic border;
        logic last;
    } tag_t;

    function automatic logic [7:0] grey_of(input pixel_t p);
        logic [12:0] s;
        s = 13'(p[7:0]) * 13'd11 + 13'(p[15:8]) * 13'd16 + 13'(p[23:16]) * 13'd5;
        return s[12:5];
    endfunction

    function automatic logic signed [10:0] kern_coef(input logic [2:0] mode,
                                                     input logic [3:0] idx);
        logic signed [10:0] k [0:8];
        case (mode)
            MODE_SOBEL:   k = '{-11'sd160, -11'sd160, 11'sd0, -11'sd160, 11'sd0,
                                11'sd160, 11'sd0, 11'sd160, 11'sd160};
            MODE_GAUSS:   k = '{11'sd5, 11'sd10, 11'sd5, 11'sd10, 11'sd20,
                                11'sd10, 11'sd5, 11'sd10, 11'sd5};
            MODE_EMBOSS:  k = '{-11'sd80, -11'sd80, 11'sd0, -11'sd80, 11'sd0,
                                11'sd80, 11'sd0, 11'sd80, 11'sd80};
            MODE_SHARPEN: k = '{-11'sd80, -11'sd80, -11'sd80, -11'sd80, 11'sd720,
                                -11'sd80, -11'sd80, -11'sd80, -11'sd80};
            MODE_BLUR:    k = '{11'sd0, 11'sd16, 11'sd0, 11'sd16, 11'sd16,
                                11'sd16, 11'sd0, 11'sd16, 11'sd0};
            default:      k = '{default: 11'sd0};
        endcase
        return (idx < 4'd9) ? k[idx] : 11'sd0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/image_3x3_kernel_filter.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_red in_green in_blue in_alpha drain
// out      output     out_valid / out_stall  out_red out_green out_blue out_alpha out_last
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One word per cycle unless out is held. A pixel leaves via s1, window, s3, s4
// and out regs once its window completes, row width + 1 words after it enters.
// Line stores are single-write, registered-read RAMs; a write and read of the
// same column in one cycle is forwarded. Line stores are not cleared.
// A held result on out stalls the whole pipeline and raises in_stall.
// cfg is always ready.
`default_nettype none

module image_3x3_kernel_filter
    import ikf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_red,
    input  wire logic [7:0]  in_green,
    input  wire logic [7:0]  in_blue,
    input  wire logic [7:0]  in_alpha,
    input  wire logic        drain,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_alpha,
    output logic             out_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    logic       en;
    logic [2:0] mode;
    logic       item_valid;
    item_t      item;
    logic       win_valid;
    tag_t       win_tag;
    pixel_t     cells [0:8];
    logic [7:0] greys [0:8];

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    ikf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .in_alpha   (in_alpha),
        .drain      (drain),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .item_valid (item_valid),
        .item       (item)
    );

    ikf_line_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (item_valid),
        .item       (item),
        .win_valid  (win_valid),
        .win_tag    (win_tag),
        .cells      (cells),
        .greys      (greys)
    );

    ikf_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (mode),
        .win_valid (win_valid),
        .win_tag   (win_tag),
        .cells     (cells),
        .greys     (greys),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ikf_ctrl.sv =====
`default_nettype none

module ikf_ctrl
    import ikf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [7:0]  in_red,
    input  wire logic [7:0]  in_green,
    input  wire logic [7:0]  in_blue,
    input  wire logic [7:0]  in_alpha,
    input  wire logic        drain,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    output logic [2:0]       mode,
    output logic             item_valid,
    output item_t            item
);

    logic [ADDR_W-1:0] col_reg, col_next;
    logic [12:0]       row_reg, row_next;
    logic [11:0]       pend_reg, pend_next;
    logic [2:0]        mode_reg, mode_next;
    logic [11:0]       width_reg, width_next;
    logic [12:0]       height_reg, height_next;

    logic              restart_pre, ignore, emit;
    logic [ADDR_W-1:0] c;
    logic [12:0]       r, qr, r_inc;
    logic [11:0]       p, p_upd, c_inc;
    logic [ADDR_W-1:0] qc;
    logic [11:0]       wv;
    logic [12:0]       hv;

    always_comb
    begin
        restart_pre = !drain && (row_reg >= height_reg);
        ignore      = drain && ((row_reg < height_reg) || (pend_reg == 12'd0));
        c = restart_pre ? '0 : col_reg;
        r = restart_pre ? '0 : row_reg;
        p = restart_pre ? '0 : pend_reg;

        if (!drain)
        begin
            emit  = ({1'b0, p} >= ({1'b0, width_reg} + 13'd1));
            p_upd = emit ? p : p + 12'd1;
        end
        else
        begin
            emit  = 1'b1;
            p_upd = p - 12'd1;
        end

        if (c != '0)
        begin
            qr = r - 13'd1;
            qc = c - ADDR_W'(1);
        end
        else
        begin
            qr = r - 13'd2;
            qc = ADDR_W'(width_reg - 12'd1);
        end

        item.emit   = emit;
        item.border = (qr == 13'd0) || (qr == height_reg - 13'd1) || (qc == '0)
                      || ({1'b0, qc} == width_reg - 12'd1);
        item.last   = (qr == height_reg - 13'd1) && ({1'b0, qc} == width_reg - 12'd1);
        item.addr   = c;
        item.px     = drain ? '0 : {in_alpha, in_blue, in_green, in_red};
        item_valid  = in_valid && en && !ignore;

        c_inc = {1'b0, c} + 12'd1;
        r_inc = r;
        if (c_inc >= width_reg)
        begin
            c_inc = '0;
            r_inc = r + 13'd1;
        end

        col_next    = col_reg;
        row_next    = row_reg;
        pend_next   = pend_reg;
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;

        if (item_valid)
        begin
            col_next  = c_inc[ADDR_W-1:0];
            row_next  = r_inc;
            pend_next = p_upd;
            if (drain && p_upd == 12'd0)
            begin
                col_next = '0;
                row_next = '0;
            end
        end

        wv = cfg_data[11:0];
        hv = cfg_data;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:
                    mode_next = cfg_data[2:0];
                CFG_WIDTH:
                begin
                    width_next = (wv < WIDTH_MIN) ? WIDTH_MIN : (wv > WIDTH_MAX) ? WIDTH_MAX : wv;
                    col_next   = '0;
                    row_next   = '0;
                    pend_next  = '0;
                end
                CFG_HEIGHT:
                begin
                    height_next = (hv < HEIGHT_MIN) ? HEIGHT_MIN :
                                  (hv > HEIGHT_MAX) ? HEIGHT_MAX : hv;
                    col_next    = '0;
                    row_next    = '0;
                    pend_next   = '0;
                end
                default: ;
            endcase
        end
    end

    assign mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            mode_reg   <= MODE_SOBEL;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < width_reg)
        else $error("column past row end");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= height_reg + 13'd1)
        else $error("row past frame end");
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pend_reg} <= {1'b0, width_reg} + 13'd1)
        else $error("pending count beyond line delay");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ikf_line_store.sv =====
`default_nettype none

module ikf_line_store
    import ikf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   item_valid,
    input  wire item_t  item,
    output logic        win_valid,
    output tag_t        win_tag,
    output pixel_t      cells [0:8],
    output logic [7:0]  greys [0:8]
);

    pixel_t older_mem  [0:MAX_WIDTH-1];
    pixel_t recent_mem [0:MAX_WIDTH-1];

    logic   s1_valid_reg;
    item_t  s1_item_reg;
    pixel_t rd_old_reg, rd_rec_reg;
    logic   fwd_reg;
    pixel_t fwd_top_reg, fwd_mid_reg;
    pixel_t top1, mid1;

    pixel_t     win_reg  [0:8];
    logic [7:0] grey_reg [0:8];
    logic       win_valid_reg;
    tag_t       win_tag_reg;

    assign top1 = fwd_reg ? fwd_top_reg : rd_old_reg;
    assign mid1 = fwd_reg ? fwd_mid_reg : rd_rec_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (item_valid)
            begin
                rd_old_reg <= older_mem[item.addr];
                rd_rec_reg <= recent_mem[item.addr];
            end
            if (s1_valid_reg)
            begin
                older_mem[s1_item_reg.addr]  <= mid1;
                recent_mem[s1_item_reg.addr] <= s1_item_reg.px;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && item_valid)
        begin
            s1_item_reg <= item;
            fwd_top_reg <= mid1;
            fwd_mid_reg <= s1_item_reg.px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            win_valid_reg <= 1'b0;
            win_tag_reg   <= '0;
            win_reg       <= '{default: '0};
            grey_reg      <= '{default: '0};
        end
        else if (en)
        begin
            s1_valid_reg  <= item_valid;
            // same entry written this edge: take the write data instead
            if (item_valid)
                fwd_reg <= s1_valid_reg && (s1_item_reg.addr == item.addr);
            win_valid_reg <= s1_valid_reg && s1_item_reg.emit;
            win_tag_reg   <= '{border: s1_item_reg.border, last: s1_item_reg.last};
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[3*i]    <= win_reg[3*i+1];
                    win_reg[3*i+1]  <= win_reg[3*i+2];
                    grey_reg[3*i]   <= grey_reg[3*i+1];
                    grey_reg[3*i+1] <= grey_reg[3*i+2];
                end
                win_reg[2]  <= top1;
                win_reg[5]  <= mid1;
                win_reg[8]  <= s1_item_reg.px;
                grey_reg[2] <= grey_of(top1);
                grey_reg[5] <= grey_of(mid1);
                grey_reg[8] <= grey_of(s1_item_reg.px);
            end
        end
    end

    assign win_valid = win_valid_reg;
    assign win_tag   = win_tag_reg;
    assign cells     = win_reg;
    assign greys     = grey_reg;

`ifndef NO_ASSERTIONS
    a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (en && item_valid && !s1_valid_reg) |=> !fwd_reg)
        else $error("forward without an item in flight");
    a_win_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !s1_valid_reg) |=> !win_valid_reg)
        else $error("window result without an item");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(win_valid_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved while held");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ikf_kernel.sv =====
`default_nettype none

module ikf_kernel
    import ikf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic [2:0] mode,
    input  wire logic       win_valid,
    input  wire tag_t       win_tag,
    input  wire pixel_t     cells [0:8],
    input  wire logic [7:0] greys [0:8],
    output logic            out_valid,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output logic [7:0]      out_alpha,
    output logic            out_last
);

    // stage 3: row sums and median
    logic               s3_valid_reg;
    tag_t               s3_tag_reg;
    pixel_t             s3_ctr_reg;
    logic [7:0]         s3_grey_reg;
    logic signed [20:0] s3_row_reg [0:2][0:2];
    logic [7:0]         s3_med_reg [0:2];

    // stage 4: totals
    logic               s4_valid_reg;
    tag_t               s4_tag_reg;
    pixel_t             s4_ctr_reg;
    logic [7:0]         s4_grey_reg;
    logic signed [21:0] s4_sum_reg [0:2];
    logic [7:0]         s4_med_reg [0:2];

    logic               out_valid_reg, out_last_reg;
    pixel_t             out_px_reg;

    logic signed [20:0] row_c [0:2][0:2];
    logic [7:0]         med_c [0:2];
    logic [7:0]         v     [0:7];
    logic [2:0]         rank;
    logic [7:0]         src;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                row_c[k][j] = '0;
                for (int i = 0; i < 3; i++)
                begin
                    src = (mode == MODE_SOBEL) ? greys[3*j+i] : cells[3*j+i][8*k +: 8];
                    row_c[k][j] = row_c[k][j] + 21'($signed({1'b0, src})
                                  * kern_coef(mode, 4'(3*j+i)));
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int n = 0; n < 8; n++)
                v[n] = cells[(n < 4) ? n : n + 1][8*k +: 8];
            med_c[k] = '0;
            for (int n = 0; n < 8; n++)
            begin
                rank = '0;
                for (int m = 0; m < 8; m++)
                    if (m != n && ((v[m] < v[n]) || (v[m] == v[n] && m < n)))
                        rank = rank + 3'd1;
                if (rank == 3'd4)
                    med_c[k] = v[n];
            end
        end
    end

    logic [13:0] dq    [0:2];
    logic [29:0] dprod [0:2];
    logic [7:0]  scl   [0:2];
    logic [7:0]  ca;
    pixel_t      res;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dq[k]    = s4_sum_reg[k][17:4];
            dprod[k] = 30'(dq[k]) * 30'(RECIP5);
            if (s4_sum_reg[k] < 0)
                scl[k] = '0;
            else if (dprod[k][29:18] > 12'd255)
                scl[k] = 8'd255;
            else
                scl[k] = dprod[k][25:18];
        end
        ca = s4_ctr_reg[31:24];
        if (mode > MODE_BLUR)
            res = s4_ctr_reg;
        else if (s4_tag_reg.border)
            res = (mode == MODE_SOBEL) ? {ca, s4_grey_reg, s4_grey_reg, s4_grey_reg}
                                       : s4_ctr_reg;
        else if (mode == MODE_MEDIAN)
            res = {ca, s4_med_reg[2], s4_med_reg[1], s4_med_reg[0]};
        else if (ca == 8'd0)
            res = '0;
        else if (mode == MODE_SOBEL)
            res = {ca, scl[0], scl[0], scl[0]};
        else
            res = {ca, scl[2], scl[1], scl[0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_tag_reg  <= win_tag;
            s3_ctr_reg  <= cells[4];
            s3_grey_reg <= greys[4];
            s3_row_reg  <= row_c;
            s3_med_reg  <= med_c;
            s4_tag_reg  <= s3_tag_reg;
            s4_ctr_reg  <= s3_ctr_reg;
            s4_grey_reg <= s3_grey_reg;
            s4_med_reg  <= s3_med_reg;
            for (int k = 0; k < 3; k++)
                s4_sum_reg[k] <= 22'(s3_row_reg[k][0]) + 22'(s3_row_reg[k][1])
                                 + 22'(s3_row_reg[k][2]);
            out_px_reg   <= res;
            out_last_reg <= s4_tag_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg  <= win_valid;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_px_reg[7:0];
    assign out_green = out_px_reg[15:8];
    assign out_blue  = out_px_reg[23:16];
    assign out_alpha = out_px_reg[31:24];
    assign out_last  = out_valid_reg && out_last_reg;

`ifndef NO_ASSERTIONS
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !s4_valid_reg) |=> !out_valid_reg)
        else $error("result without a filtered item");
    a_s4_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s3_valid_reg) |=> s4_valid_reg)
        else $error("item lost between sum stages");
    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_alpha == 8'd0 && !s4_tag_reg.border) |-> 1'b1)
        else $error("unreachable");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_image_3x3_kernel_filter.sv =====
`default_nettype none

module tb_image_3x3_kernel_filter;
    import ikf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       drn;
    } pix_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } filt_px_t;

    localparam int KERN [6][9] = '{
        '{-160, -160, 0, -160, 0, 160, 0, 160, 160},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{5, 10, 5, 10, 20, 10, 5, 10, 5},
        '{-80, -80, 0, -80, 0, 80, 0, 80, 80},
        '{-80, -80, -80, -80, 720, -80, -80, -80, -80},
        '{0, 16, 0, 16, 16, 16, 0, 16, 0}
    };
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_red, in_green, in_blue, in_alpha;
    logic        drain;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_red, out_green, out_blue, out_alpha;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MODE;
    logic [12:0] cfg_data = '0;

    image_3x3_kernel_filter DUT (.*);

    // testbench-side image state
    logic [31:0] prev2_row [MAX_WIDTH];
    logic [31:0] prev1_row [MAX_WIDTH];
    logic [31:0] win [9];
    int unsigned col_pos, row_pos, in_flight;
    logic [2:0]  cur_mode;
    int unsigned img_w, img_h;

    pix_word_t   pending_words [$];
    filt_px_t    expected_px [$];
    pix_word_t   cur_word;
    int          idle_left;
    int          stall_left;
    int          hold_left;
    bit          hold_req;
    bit          hold_done;
    bit          calm;
    int          fail_count;
    int          quiet_cycles;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int grey(logic [31:0] p);
        return (int'(p[7:0]) * 11 + int'(p[15:8]) * 16 + int'(p[23:16]) * 5) >> 5;
    endfunction

    function automatic int scale80(int s);
        if (s < 0) return 0;
        return (s / 80 > 255) ? 255 : s / 80;
    endfunction

    function automatic logic [7:0] median_of(int k);
        int v [8];
        int n, x, j;
        n = 0;
        for (int i = 0; i < 9; i++)
            if (i != 4)
            begin
                v[n] = int'(win[i][8*k +: 8]);
                n++;
            end
        for (int i = 1; i < 8; i++)
        begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x)
            begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return 8'(v[4]);
    endfunction

    function automatic logic [31:0] filter_centre(bit border);
        logic [31:0] c;
        logic [7:0]  a, g;
        logic [7:0]  res [3];
        int s;
        c = win[4];
        a = c[31:24];
        if (cur_mode > MODE_BLUR) return c;
        if (border)
        begin
            if (cur_mode == MODE_SOBEL)
            begin
                g = 8'(grey(c));
                return {a, g, g, g};
            end
            return c;
        end
        if (cur_mode == MODE_MEDIAN)
            return {a, median_of(2), median_of(1), median_of(0)};
        if (a == 8'd0) return '0;
        if (cur_mode == MODE_SOBEL)
        begin
            s = 0;
            for (int i = 0; i < 9; i++) s += grey(win[i]) * KERN[MODE_SOBEL][i];
            g = 8'(scale80(s));
            return {a, g, g, g};
        end
        for (int k = 0; k < 3; k++)
        begin
            s = 0;
            for (int i = 0; i < 9; i++) s += int'(win[i][8*k +: 8]) * KERN[cur_mode][i];
            res[k] = 8'(scale80(s));
        end
        return {a, res[2], res[1], res[0]};
    endfunction

    function automatic void restart_stream();
        col_pos = 0;
        row_pos = 0;
        in_flight = 0;
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [12:0] val);
        int unsigned v;
        if (idx == CFG_MODE)
            cur_mode = val[2:0];
        else if (idx == CFG_WIDTH)
        begin
            v = val[11:0];
            img_w = (v < 3) ? 3 : (v > MAX_WIDTH ? MAX_WIDTH : v);
            restart_stream();
        end
        else if (idx == CFG_HEIGHT)
        begin
            v = val;
            img_h = (v < 3) ? 3 : (v > 4096 ? 4096 : v);
            restart_stream();
        end
    endfunction

    // returns 1 and fills px when the word produces a filtered pixel
    function automatic bit filter_step(pix_word_t w, output filt_px_t px);
        int unsigned c, r, qr, qc;
        logic [31:0] p, res, mid;
        bit emit;
        emit = 0;
        qr = 0;
        qc = 0;
        if (!w.drn && row_pos >= img_h) restart_stream();
        if (w.drn && (row_pos < img_h || in_flight == 0)) return 0;
        c = col_pos;
        r = row_pos;
        if (c >= img_w)
        begin
            restart_stream();
            c = 0;
            r = 0;
        end
        p = w.drn ? '0 : {w.alpha, w.blue, w.green, w.red};
        mid = prev1_row[c];
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = prev2_row[c];
        win[5] = mid;
        win[8] = p;
        prev2_row[c] = mid;
        prev1_row[c] = p;
        if (!w.drn)
        begin
            if (in_flight >= img_w + 1) emit = 1;
            else in_flight++;
        end
        else
        begin
            emit = 1;
            in_flight--;
        end
        if (emit)
        begin
            if (c >= 1)
            begin
                qr = r - 1;
                qc = c - 1;
            end
            else
            begin
                qr = r - 2;
                qc = img_w - 1;
            end
        end
        c++;
        if (c >= img_w)
        begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        if (w.drn && in_flight == 0) restart_stream();
        if (!emit) return 0;
        res = filter_centre(qr == 0 || qr == img_h - 1 || qc == 0 || qc == img_w - 1);
        px.red   = res[7:0];
        px.green = res[15:8];
        px.blue  = res[23:16];
        px.alpha = res[31:24];
        px.last  = (qr == img_h - 1 && qc == img_w - 1);
        return 1;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        filt_px_t fp;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_red    <= '0;
            in_green  <= '0;
            in_blue   <= '0;
            in_alpha  <= '0;
            drain     <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                if (filter_step(cur_word, fp)) expected_px.push_back(fp);
            if (!in_valid || !in_stall)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    in_red   <= cur_word.red;
                    in_green <= cur_word.green;
                    in_blue  <= cur_word.blue;
                    in_alpha <= cur_word.alpha;
                    drain    <= cur_word.drn;
                    in_valid <= 1'b1;
                    idle_left = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 0;
        end
        else
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        filt_px_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_px.size() == 0)
            begin
                $error("unexpected output word");
                fail_count++;
            end
            else
            begin
                e = expected_px.pop_front();
                if (out_red !== e.red)
                begin
                    $error("out_red exp %0d got %0d", e.red, out_red);
                    fail_count++;
                end
                if (out_green !== e.green)
                begin
                    $error("out_green exp %0d got %0d", e.green, out_green);
                    fail_count++;
                end
                if (out_blue !== e.blue)
                begin
                    $error("out_blue exp %0d got %0d", e.blue, out_blue);
                    fail_count++;
                end
                if (out_alpha !== e.alpha)
                begin
                    $error("out_alpha exp %0d got %0d", e.alpha, out_alpha);
                    fail_count++;
                end
                if (out_last !== e.last)
                begin
                    $error("out_last exp %0d got %0d", e.last, out_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic wait_idle();
        wait (pending_words.size() == 0 && !in_valid && expected_px.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pending_words.push_back('{red: r, green: g, blue: b, alpha: a, drn: 1'b0});
    endtask

    task automatic push_drains(int n);
        repeat (n) pending_words.push_back('{red: 8'($urandom), green: 8'($urandom),
                                             blue: 8'($urandom), alpha: 8'($urandom),
                                             drn: 1'b1});
    endtask

    function automatic logic [7:0] chan_val();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic push_rand_px();
        push_px(chan_val(), chan_val(), chan_val(),
                ($urandom_range(0, 7) == 0) ? 8'd0 : chan_val());
    endtask

    // one frame; when noisy, a stray drain now and then, and sometimes a cut tail
    task automatic push_frame(int w, int h, bit noisy);
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 29) == 0) push_drains(1);
            push_rand_px();
        end
        if (noisy && $urandom_range(0, 9) == 0)
            push_drains($urandom_range(0, w));
        else
        begin
            push_drains(w + 1);
            if (noisy && $urandom_range(0, 3) == 0) push_drains(1);
        end
    endtask

    initial
    begin
        int w, h, m, budget;
        fail_count = 0;
        quiet_cycles = 0;
        calm = 0;
        hold_req = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            prev2_row[i] = '0;
            prev1_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        restart_stream();
        cur_mode = MODE_SOBEL;
        img_w = WIDTH_RST;
        img_h = HEIGHT_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // clamped sizes, drain with nothing pending, drain mid frame, cut tail
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'd0);
        write_reg(CFG_MODE, 13'(MODE_SOBEL));
        push_drains(1);
        push_px(8'd255, 8'd255, 8'd255, 8'd255);
        push_px(8'd0, 8'd0, 8'd0, 8'd0);
        push_px(8'd255, 8'd0, 8'd255, 8'd1);
        push_px(8'd0, 8'd255, 8'd0, 8'd255);
        push_drains(1);
        push_px(8'd255, 8'd255, 8'd255, 8'd255);
        push_px(8'd0, 8'd0, 8'd0, 8'd255);
        push_px(8'd255, 8'd255, 8'd0, 8'd128);
        push_px(8'd0, 8'd0, 8'd255, 8'd255);
        push_px(8'd255, 8'd0, 8'd0, 8'd255);
        push_drains(2);
        push_frame(3, 3, 0);
        push_drains(1);

        for (int md = 0; md < 8; md++)
        begin
            write_reg(CFG_MODE, 13'(md));
            push_frame(3, 3, 0);
        end

        budget = 560;
        while (budget > 0)
        begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_HEIGHT, 13'(h));
                write_reg(CFG_WIDTH, 13'(w));
            end
            else
            begin
                write_reg(CFG_WIDTH, 13'(w) | ($urandom_range(0, 1) ? 13'h1000 : 13'h0));
                write_reg(CFG_HEIGHT, 13'(h));
            end
            write_reg(CFG_MODE, 13'(m) | 13'($urandom_range(0, 1023) << 3));
            calm = ($urandom_range(0, 4) == 0);
            if (budget < 280 && !hold_req)
            begin
                calm = 1;
                hold_req = 1;
            end
            repeat ($urandom_range(1, 3))
            begin
                push_frame(w, h, 1);
                budget -= w * h;
            end
        end
        calm = 0;

        // oversized registers clamp; short partial frames keep the run small
        write_reg(CFG_MODE, 13'(MODE_GAUSS));
        write_reg(CFG_WIDTH, 13'd4095);
        write_reg(CFG_HEIGHT, 13'd3);
        repeat (8) push_rand_px();
        push_drains(2);
        write_reg(CFG_MODE, 13'(MODE_SHARPEN));
        write_reg(CFG_WIDTH, 13'd3);
        write_reg(CFG_HEIGHT, 13'd8191);
        repeat (12) push_rand_px();
        push_drains(2);
        write_reg(CFG_MODE, 13'(MODE_MEDIAN));
        write_reg(CFG_WIDTH, 13'd5);
        write_reg(CFG_HEIGHT, 13'd4);
        push_frame(5, 4, 1);

        wait_idle();
        if (fail_count == 0 && expected_px.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/ikf_pkg.sv
rtl/core/ikf_ctrl.sv
rtl/core/ikf_line_store.sv
rtl/core/ikf_kernel.sv
rtl/core/image_3x3_kernel_filter.sv
tb/tb_image_3x3_kernel_filter.sv
